[rtl/core/assert_macros.svh]
// Assertion helpers used by the controller RTL module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RAMCT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RAMCT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/ramct_pkg.sv]
package ramct_pkg;

    // Tree geometry: a full binary tree over MAX_ELEMENTS leaves, heap numbered from 1.
    localparam int LEAF_BITS    = 16;
    localparam int MAX_ELEMENTS = 1 << LEAF_BITS;
    localparam int NODE_BITS    = LEAF_BITS + 1;
    localparam int NODE_COUNT   = 1 << NODE_BITS;
    localparam int WALK_BITS    = LEAF_BITS + 2;
    localparam int LVL_BITS     = $clog2(LEAF_BITS + 1);
    localparam int CNT_BITS     = 17;
    localparam int IDX_BITS     = 16;

    localparam logic [WALK_BITS-1:0] LEAF_BASE = WALK_BITS'(MAX_ELEMENTS);

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_COUNT = 1'b1;

    typedef logic [CNT_BITS-1:0] cnt_t;

    // One tree node: element counts per residue and the shift still owed to the children.
    typedef struct packed {
        logic [1:0] lazy;
        cnt_t       c2;
        cnt_t       c1;
        cnt_t       c0;
    } node_t;

    typedef enum logic [1:0] {
        PSRC_L0,
        PSRC_R0,
        PSRC_WL,
        PSRC_WR
    } psrc_t;

    typedef enum logic [1:0] {
        RA_SRC,
        RA_SRC_C0,
        RA_C0,
        RA_C1
    } raddr_t;

    typedef enum logic [2:0] {
        WOP_CLEAR,
        WOP_LAZY_CLEAR,
        WOP_ROT_C0,
        WOP_ROT_C1,
        WOP_APPLY,
        WOP_SUM
    } wop_t;

    typedef struct packed {
        logic   load;
        logic   lvl_top;
        logic   lvl_bot;
        logic   lvl_dec;
        logic   lvl_inc;
        logic   p_load;
        psrc_t  p_sel;
        logic   w_init;
        logic   wl_inc;
        logic   wr_dec;
        logic   w_shift;
        logic   rd_en;
        raddr_t rd_sel;
        logic   wr_en;
        wop_t   wr_op;
        logic   shift_save;
        logic   tmp_save;
        logic   acc_add;
        logic   res_fire;
        logic   clr_step;
    } ctl_t;

    typedef struct packed {
        logic is_count;
        logic empty;
        logic cond_l;
        logic cond_r;
        logic lvl_first;
        logic lvl_last;
        logic lazy_zero;
        logic w_lt;
        logic wl_odd;
        logic wr_odd;
        logic clr_done;
    } stat_t;

    // Apply a shift of s (0 to 2) to a node: rotate the residue counts and add to the lazy shift.
    function automatic node_t node_rotate(node_t e, logic [1:0] s);
        node_t      r;
        logic [2:0] sum;
        r = e;
        case (s)
            2'd1:
            begin
                r.c0 = e.c2;
                r.c1 = e.c0;
                r.c2 = e.c1;
            end
            2'd2:
            begin
                r.c0 = e.c1;
                r.c1 = e.c2;
                r.c2 = e.c0;
            end
            default:
            begin
                r = e;
            end
        endcase
        sum = {1'b0, e.lazy} + {1'b0, s};
        r.lazy = (sum >= 3'd3) ? 2'(sum - 3'd3) : sum[1:0];
        return r;
    endfunction

endpackage

[rtl/core/ramct_dpath.sv]
module ramct_dpath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_fire,
    input  logic [ramct_pkg::CNT_BITS-1:0] cfg_data,
    input  logic                          cmd,
    input  logic [ramct_pkg::IDX_BITS-1:0] range_low,
    input  logic [ramct_pkg::IDX_BITS-1:0] range_high,
    input  ramct_pkg::ctl_t               ctl,
    output ramct_pkg::stat_t              st,
    output logic [ramct_pkg::CNT_BITS-1:0] multiple_count
);
    import ramct_pkg::*;

    cnt_t                 n_reg;
    cnt_t                 clr_lo_reg;
    cnt_t                 clr_size_reg;
    logic [NODE_BITS-1:0] clr_addr_reg;
    logic [WALK_BITS-1:0] l0_reg;
    logic [WALK_BITS-1:0] r0_reg;
    logic [WALK_BITS-1:0] wl_reg;
    logic [WALK_BITS-1:0] wr_reg;
    logic [LVL_BITS-1:0]  lvl_reg;
    logic                 cmd_reg;
    logic                 empty_reg;
    logic [NODE_BITS-1:0] p_reg;
    logic [1:0]           shift_reg;
    node_t                rdata_reg;
    node_t                tmp_reg;
    cnt_t                 acc_reg;
    cnt_t                 mult_reg;
    node_t                mem_array [NODE_COUNT];

    cnt_t                 cfg_n;
    cnt_t                 nm1;
    logic [IDX_BITS-1:0]  b_clip;
    cnt_t                 clr_lo_sum;
    cnt_t                 clr_span;
    cnt_t                 clr_c0;
    logic [WALK_BITS-1:0] r0m1;
    logic [WALK_BITS-1:0] l0_sh;
    logic [WALK_BITS-1:0] r0_sh;
    logic [WALK_BITS-1:0] wr_m1;
    logic [WALK_BITS-1:0] lvl_mask;
    logic [NODE_BITS-1:0] src;
    logic [NODE_BITS-1:0] raddr;
    logic [NODE_BITS-1:0] waddr;
    node_t                wdata;

    // Size register is clamped to the legal range on the way in.
    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_n = CNT_BITS'(1);
        end
        else if (cfg_data > CNT_BITS'(MAX_ELEMENTS))
        begin
            cfg_n = CNT_BITS'(MAX_ELEMENTS);
        end
        else
        begin
            cfg_n = cfg_data;
        end
    end

    assign nm1    = n_reg - CNT_BITS'(1);
    assign b_clip = ({1'b0, range_high} > nm1) ? nm1[IDX_BITS-1:0] : range_high;

    // Clearing sweep: node count of zero-residue elements is the part of its span below n.
    assign clr_lo_sum = clr_lo_reg + clr_size_reg;
    assign clr_span   = n_reg - clr_lo_reg;
    assign clr_c0     = (n_reg > clr_lo_reg) ?
                        ((clr_span > clr_size_reg) ? clr_size_reg : clr_span) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg        <= CNT_BITS'(MAX_ELEMENTS);
            clr_addr_reg <= NODE_BITS'(1);
            clr_lo_reg   <= '0;
            clr_size_reg <= CNT_BITS'(MAX_ELEMENTS);
        end
        else if (cfg_fire)
        begin
            n_reg        <= cfg_n;
            clr_addr_reg <= NODE_BITS'(1);
            clr_lo_reg   <= '0;
            clr_size_reg <= CNT_BITS'(MAX_ELEMENTS);
        end
        else if (ctl.clr_step)
        begin
            clr_addr_reg <= clr_addr_reg + NODE_BITS'(1);
            if (clr_lo_sum == CNT_BITS'(MAX_ELEMENTS))
            begin
                clr_lo_reg   <= '0;
                clr_size_reg <= clr_size_reg >> 1;
            end
            else
            begin
                clr_lo_reg <= clr_lo_sum;
            end
        end
    end

    // Walk addresses.
    assign r0m1     = r0_reg - WALK_BITS'(1);
    assign wr_m1    = wr_reg - WALK_BITS'(1);
    assign l0_sh    = l0_reg >> lvl_reg;
    assign r0_sh    = r0m1 >> lvl_reg;
    assign lvl_mask = ~({WALK_BITS{1'b1}} << lvl_reg);

    always_comb
    begin
        case (ctl.p_sel)
            PSRC_L0: src = l0_sh[NODE_BITS-1:0];
            PSRC_R0: src = r0_sh[NODE_BITS-1:0];
            PSRC_WL: src = wl_reg[NODE_BITS-1:0];
            PSRC_WR: src = wr_m1[NODE_BITS-1:0];
            default: src = wl_reg[NODE_BITS-1:0];
        endcase
    end

    always_comb
    begin
        case (ctl.rd_sel)
            RA_SRC:    raddr = src;
            RA_SRC_C0: raddr = {src[NODE_BITS-2:0], 1'b0};
            RA_C0:     raddr = {p_reg[NODE_BITS-2:0], 1'b0};
            RA_C1:     raddr = {p_reg[NODE_BITS-2:0], 1'b1};
            default:   raddr = src;
        endcase
    end

    always_comb
    begin
        waddr = p_reg;
        wdata = rdata_reg;
        case (ctl.wr_op)
            WOP_CLEAR:
            begin
                waddr    = clr_addr_reg;
                wdata.c0 = clr_c0;
                wdata.c1 = '0;
                wdata.c2 = '0;
                wdata.lazy = 2'd0;
            end
            WOP_LAZY_CLEAR:
            begin
                wdata.lazy = 2'd0;
            end
            WOP_ROT_C0:
            begin
                waddr = {p_reg[NODE_BITS-2:0], 1'b0};
                wdata = node_rotate(rdata_reg, shift_reg);
            end
            WOP_ROT_C1:
            begin
                waddr = {p_reg[NODE_BITS-2:0], 1'b1};
                wdata = node_rotate(rdata_reg, shift_reg);
            end
            WOP_APPLY:
            begin
                wdata = node_rotate(rdata_reg, 2'd1);
            end
            WOP_SUM:
            begin
                wdata.c0   = tmp_reg.c0 + rdata_reg.c0;
                wdata.c1   = tmp_reg.c1 + rdata_reg.c1;
                wdata.c2   = tmp_reg.c2 + rdata_reg.c2;
                wdata.lazy = 2'd0;
            end
            default:
            begin
                wdata = rdata_reg;
            end
        endcase
    end

    // Node store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem_array[waddr] <= wdata;
        end
        if (ctl.rd_en)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd;
            empty_reg <= (range_low > b_clip);
            l0_reg    <= WALK_BITS'(range_low) + LEAF_BASE;
            r0_reg    <= WALK_BITS'(b_clip) + LEAF_BASE + WALK_BITS'(1);
            acc_reg   <= '0;
        end
        else if (ctl.acc_add)
        begin
            acc_reg <= acc_reg + rdata_reg.c0;
        end
        if (ctl.lvl_top)
        begin
            lvl_reg <= LVL_BITS'(LEAF_BITS);
        end
        else if (ctl.lvl_bot)
        begin
            lvl_reg <= LVL_BITS'(1);
        end
        else if (ctl.lvl_dec)
        begin
            lvl_reg <= lvl_reg - LVL_BITS'(1);
        end
        else if (ctl.lvl_inc)
        begin
            lvl_reg <= lvl_reg + LVL_BITS'(1);
        end
        if (ctl.w_init)
        begin
            wl_reg <= l0_reg;
            wr_reg <= r0_reg;
        end
        else if (ctl.w_shift)
        begin
            wl_reg <= wl_reg >> 1;
            wr_reg <= wr_reg >> 1;
        end
        else
        begin
            if (ctl.wl_inc)
            begin
                wl_reg <= wl_reg + WALK_BITS'(1);
            end
            if (ctl.wr_dec)
            begin
                wr_reg <= wr_m1;
            end
        end
        if (ctl.p_load)
        begin
            p_reg <= src;
        end
        if (ctl.shift_save)
        begin
            shift_reg <= rdata_reg.lazy;
        end
        if (ctl.tmp_save)
        begin
            tmp_reg <= rdata_reg;
        end
        if (ctl.res_fire)
        begin
            mult_reg <= acc_reg;
        end
    end

    assign multiple_count = mult_reg;

    assign st.is_count  = (cmd_reg == CMD_COUNT);
    assign st.empty     = empty_reg;
    assign st.cond_l    = ((l0_reg & lvl_mask) != '0);
    assign st.cond_r    = ((r0_reg & lvl_mask) != '0);
    assign st.lvl_first = (lvl_reg == LVL_BITS'(1));
    assign st.lvl_last  = (lvl_reg == LVL_BITS'(LEAF_BITS));
    assign st.lazy_zero = (rdata_reg.lazy == 2'd0);
    assign st.w_lt      = (wl_reg < wr_reg);
    assign st.wl_odd    = wl_reg[0];
    assign st.wr_odd    = wr_reg[0];
    assign st.clr_done  = (clr_addr_reg == '1);

endmodule

[rtl/core/ramct_ctrl.sv]
`include "assert_macros.svh"

module ramct_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              cfg_fire,
    input  ramct_pkg::stat_t  st,
    output ramct_pkg::ctl_t   ctl,
    output logic              busy,
    output logic              cfg_ready,
    output logic              done
);
    import ramct_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_PL_SEL,
        S_PR_SEL,
        S_PU_B,
        S_PU_C,
        S_PU_D,
        S_AP_TEST,
        S_AP_RCHK,
        S_AP_DATA,
        S_UL_SEL,
        S_UR_SEL,
        S_UP_B,
        S_UP_C
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   side_reg;
    logic   side_next;
    logic   done_reg;
    logic   done_next;
    logic   push_end;
    logic   up_end;

    always_comb
    begin
        ctl        = '0;
        state_next = state_reg;
        side_next  = side_reg;
        done_next  = 1'b0;
        push_end   = 1'b0;
        up_end     = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                ctl.wr_en    = 1'b1;
                ctl.wr_op    = WOP_CLEAR;
                ctl.clr_step = 1'b1;
                if (st.clr_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (st.empty)
                begin
                    if (st.is_count)
                    begin
                        ctl.res_fire = 1'b1;
                        done_next    = 1'b1;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    ctl.lvl_top = 1'b1;
                    state_next  = S_PL_SEL;
                end
            end
            S_PL_SEL:
            begin
                side_next = 1'b0;
                if (st.cond_l)
                begin
                    ctl.p_load = 1'b1;
                    ctl.p_sel  = PSRC_L0;
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_SRC;
                    state_next = S_PU_B;
                end
                else
                begin
                    state_next = S_PR_SEL;
                end
            end
            S_PR_SEL:
            begin
                side_next = 1'b1;
                if (st.cond_r)
                begin
                    ctl.p_load = 1'b1;
                    ctl.p_sel  = PSRC_R0;
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_SRC;
                    state_next = S_PU_B;
                end
                else
                begin
                    push_end = 1'b1;
                end
            end
            S_PU_B:
            begin
                if (st.lazy_zero)
                begin
                    if (side_reg)
                    begin
                        push_end = 1'b1;
                    end
                    else
                    begin
                        state_next = S_PR_SEL;
                    end
                end
                else
                begin
                    ctl.shift_save = 1'b1;
                    ctl.wr_en      = 1'b1;
                    ctl.wr_op      = WOP_LAZY_CLEAR;
                    ctl.rd_en      = 1'b1;
                    ctl.rd_sel     = RA_C0;
                    state_next     = S_PU_C;
                end
            end
            S_PU_C:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_op  = WOP_ROT_C0;
                ctl.rd_en  = 1'b1;
                ctl.rd_sel = RA_C1;
                state_next = S_PU_D;
            end
            S_PU_D:
            begin
                ctl.wr_en = 1'b1;
                ctl.wr_op = WOP_ROT_C1;
                if (side_reg)
                begin
                    push_end = 1'b1;
                end
                else
                begin
                    state_next = S_PR_SEL;
                end
            end
            S_AP_TEST:
            begin
                if (!st.w_lt)
                begin
                    if (st.is_count)
                    begin
                        ctl.res_fire = 1'b1;
                        done_next    = 1'b1;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        ctl.lvl_bot = 1'b1;
                        state_next  = S_UL_SEL;
                    end
                end
                else if (st.wl_odd)
                begin
                    ctl.p_load = 1'b1;
                    ctl.p_sel  = PSRC_WL;
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_SRC;
                    ctl.wl_inc = 1'b1;
                    side_next  = 1'b0;
                    state_next = S_AP_DATA;
                end
                else if (st.wr_odd)
                begin
                    ctl.p_load = 1'b1;
                    ctl.p_sel  = PSRC_WR;
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_SRC;
                    ctl.wr_dec = 1'b1;
                    side_next  = 1'b1;
                    state_next = S_AP_DATA;
                end
                else
                begin
                    ctl.w_shift = 1'b1;
                end
            end
            S_AP_RCHK:
            begin
                if (st.wr_odd)
                begin
                    ctl.p_load = 1'b1;
                    ctl.p_sel  = PSRC_WR;
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_SRC;
                    ctl.wr_dec = 1'b1;
                    side_next  = 1'b1;
                    state_next = S_AP_DATA;
                end
                else
                begin
                    ctl.w_shift = 1'b1;
                    state_next  = S_AP_TEST;
                end
            end
            S_AP_DATA:
            begin
                if (st.is_count)
                begin
                    ctl.acc_add = 1'b1;
                end
                else
                begin
                    ctl.wr_en = 1'b1;
                    ctl.wr_op = WOP_APPLY;
                end
                if (side_reg)
                begin
                    ctl.w_shift = 1'b1;
                    state_next  = S_AP_TEST;
                end
                else
                begin
                    state_next = S_AP_RCHK;
                end
            end
            S_UL_SEL:
            begin
                side_next = 1'b0;
                if (st.cond_l)
                begin
                    ctl.p_load = 1'b1;
                    ctl.p_sel  = PSRC_L0;
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_SRC_C0;
                    state_next = S_UP_B;
                end
                else
                begin
                    state_next = S_UR_SEL;
                end
            end
            S_UR_SEL:
            begin
                side_next = 1'b1;
                if (st.cond_r)
                begin
                    ctl.p_load = 1'b1;
                    ctl.p_sel  = PSRC_R0;
                    ctl.rd_en  = 1'b1;
                    ctl.rd_sel = RA_SRC_C0;
                    state_next = S_UP_B;
                end
                else
                begin
                    up_end = 1'b1;
                end
            end
            S_UP_B:
            begin
                ctl.tmp_save = 1'b1;
                ctl.rd_en    = 1'b1;
                ctl.rd_sel   = RA_C1;
                state_next   = S_UP_C;
            end
            S_UP_C:
            begin
                ctl.wr_en = 1'b1;
                ctl.wr_op = WOP_SUM;
                if (side_reg)
                begin
                    up_end = 1'b1;
                end
                else
                begin
                    state_next = S_UR_SEL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // End of one level of the downward push pass.
        if (push_end)
        begin
            if (st.lvl_first)
            begin
                ctl.w_init = 1'b1;
                state_next = S_AP_TEST;
            end
            else
            begin
                ctl.lvl_dec = 1'b1;
                state_next  = S_PL_SEL;
            end
        end

        // End of one level of the upward rebuild pass.
        if (up_end)
        begin
            if (st.lvl_last)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                ctl.lvl_inc = 1'b1;
                state_next  = S_UL_SEL;
            end
        end

        if (cfg_fire)
        begin
            state_next = S_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            side_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            side_reg  <= side_next;
            done_reg  <= done_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_CLEAR);
    assign done      = done_reg;

    `RAMCT_ASSERT_NXT(a_done_pulse, clk, rst_n, done_reg, !done_reg, "result strobe held")
    `RAMCT_ASSERT_NXT(a_start_busy, clk, rst_n, start && !busy, busy, "item taken but not busy")
    `RAMCT_ASSERT_NXT(a_cfg_clear, clk, rst_n, cfg_fire, state_reg == S_CLEAR, "no clear on size write")
    `RAMCT_ASSERT_IMP(a_done_idle, clk, rst_n, done_reg, state_reg == S_IDLE, "result while walking")

endmodule

[rtl/core/range_add_mod3_count_tree_top.sv]
// Range add modulo three and count of multiples of three over an array of up to 65536
// counters. Raise start with cmd, range_low and range_high while busy is low; the item is
// taken at that edge. An add item gives no result; a count item gives one result, shown on
// multiple_count for exactly one cycle while done is high, and the receiver cannot stall it,
// so it must take the value in that cycle. An item with an empty range ends at the range
// check. Other items walk down the two boundary paths of a 17-level segment tree, pushing
// any lazy shift down at each node on the way, then run an apply pass over at most two nodes
// per level, and for an add a rebuild pass back up both paths. Every node access goes through
// the single read and single write port of the node store. After reset, and after every
// write of the size register, a clearing pass writes all 131071 tree nodes at one per
// cycle; busy stays high until it ends, and size writes are still taken during it.
module range_add_mod3_count_tree_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cmd,
    input  logic [ramct_pkg::IDX_BITS-1:0] range_low,
    input  logic [ramct_pkg::IDX_BITS-1:0] range_high,
    output logic                           done,
    output logic [ramct_pkg::CNT_BITS-1:0] multiple_count,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ramct_pkg::CNT_BITS-1:0] cfg_data
);
    import ramct_pkg::*;

    ctl_t  ctl;
    stat_t st;
    logic  cfg_fire;

    // A size write is taken while the block is idle or clearing, and restarts the clear.
    assign cfg_fire = cfg_valid && cfg_ready;

    ramct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cfg_fire  (cfg_fire),
        .st        (st),
        .ctl       (ctl),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .done      (done)
    );

    // The datapath holds the node store, the walk registers and the size register.
    ramct_dpath u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_fire       (cfg_fire),
        .cfg_data       (cfg_data),
        .cmd            (cmd),
        .range_low      (range_low),
        .range_high     (range_high),
        .ctl            (ctl),
        .st             (st),
        .multiple_count (multiple_count)
    );

endmodule
